@@ rtl/core/two_wire_link_master_crc8_core_assert.svh @@
// assertion macros for the two-wire link master core
// no dependencies; included by two_wire_link_master_crc8_core, the module that carries assertions
`ifndef TWO_WIRE_LINK_MASTER_CRC8_CORE_ASSERT_SVH
`define TWO_WIRE_LINK_MASTER_CRC8_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define TWLM_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define TWLM_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/twlm_pkg.sv @@
// shared constants, types and the crc bit step for the two-wire link master
// no dependencies
package twlm_pkg;

  localparam logic [7:0] CRC_POLY        = 8'h8C;
  localparam logic [7:0] SETPOINT_MAX_IN = 8'd26;
  localparam logic [5:0] SETPOINT_OFFSET = 6'd29;

  // schedule steps
  localparam int STEP_START_LO = 0;
  localparam int STEP_START_HI = 1;
  localparam int STEP_STOP_HI  = 18;
  localparam int STEP_STOP_LO  = 19;
  localparam int STEP_RELEASE  = 20;
  localparam int RX_START      = 22;
  localparam int STEPS_PER_BYTE = 16;

  // control from the step sequencer to the receive shifter
  typedef struct packed {
    logic clear;
    logic shift;
    logic crc_en;
    logic rx_bit;
  } rx_ctrl_t;

  // one bit of the reflected crc-8
  function automatic logic [7:0] crc8_bit(input logic [7:0] crc, input logic b);
    logic fb;
    fb = crc[0] ^ b;
    crc8_bit = {1'b0, crc[7:1]} ^ (fb ? CRC_POLY : 8'h00);
  endfunction

endpackage

@@ rtl/core/twlm_if.sv @@
// valid/ready channel interfaces for tick items and result items
// no dependencies
interface twlm_tick_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic       sda_in;
  logic [7:0] tx_byte;

  modport source (output valid, cmd, sda_in, tx_byte, input ready);
  modport sink   (input valid, cmd, sda_in, tx_byte, output ready);
endinterface

interface twlm_result_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic       crc_ok;
  logic [7:0] rx_first;
  logic [7:0] rx_second;
  logic       setpoint_update;
  logic [5:0] setpoint;

  modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  crc_ok, rx_first, rx_second, setpoint_update, setpoint,
                  input ready);
  modport sink   (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  crc_ok, rx_first, rx_second, setpoint_update, setpoint,
                  output ready);
endinterface

@@ rtl/core/twlm_rx_crc.sv @@
// receive shift register with running reflected crc-8
// depends on twlm_pkg
module twlm_rx_crc #(
  parameter int RX_BYTES = 3
) (
  input  logic                    clk,
  input  logic                    rst,
  input  twlm_pkg::rx_ctrl_t      ctrl,
  output logic [8*RX_BYTES-1:0]   rx_bits,
  output logic [7:0]              rx_crc
);

  localparam int RxBits = 8 * RX_BYTES;

  // bits arrive lsb first, byte 0 first: shifting in at the top leaves byte 0 at [7:0]
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_bits <= '0;
      rx_crc  <= '0;
    end else if (ctrl.clear) begin
      rx_bits <= '0;
      rx_crc  <= '0;
    end else if (ctrl.shift) begin
      rx_bits <= {ctrl.rx_bit, rx_bits[RxBits-1:1]};
      if (ctrl.crc_en) begin
        rx_crc <= twlm_pkg::crc8_bit(rx_crc, ctrl.rx_bit);
      end
    end
  end

endmodule

@@ rtl/core/two_wire_link_master_crc8_core.sv @@
// two-wire link master: one schedule step per accepted tick, result registered
// result appears in the cycle after the transfer; throughput one item per cycle while results.ready is high
// a new item is taken while the previous result waits, if results.ready is high
// crc is accumulated one bit per received data bit in twlm_rx_crc, so the finish step is short
// rst (synchronous) returns to idle with clock and data high, data driven, bytes cleared
// depends on twlm_pkg, twlm_if, twlm_rx_crc and the assertion macro header
`include "two_wire_link_master_crc8_core_assert.svh"

module two_wire_link_master_crc8_core #(
  parameter int RX_BYTES = 3
) (
  input  logic          clk,
  input  logic          rst,
  twlm_tick_if.sink     ticks,
  twlm_result_if.source results
);

  localparam int RxBits  = 8 * RX_BYTES;
  localparam int RxEnd   = twlm_pkg::RX_START + twlm_pkg::STEPS_PER_BYTE * RX_BYTES;
  localparam int CrcEnd  = RxEnd - twlm_pkg::STEPS_PER_BYTE;
  localparam int StepW   = $clog2(RxEnd + 1);

  localparam logic [StepW-1:0] SStartLo = StepW'(twlm_pkg::STEP_START_LO);
  localparam logic [StepW-1:0] SStartHi = StepW'(twlm_pkg::STEP_START_HI);
  localparam logic [StepW-1:0] SStopHi  = StepW'(twlm_pkg::STEP_STOP_HI);
  localparam logic [StepW-1:0] SStopLo  = StepW'(twlm_pkg::STEP_STOP_LO);
  localparam logic [StepW-1:0] SRelease = StepW'(twlm_pkg::STEP_RELEASE);
  localparam logic [StepW-1:0] SCrcEnd  = StepW'(CrcEnd);
  localparam logic [StepW-1:0] SEnd     = StepW'(RxEnd);

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic       crc_ok;
    logic [7:0] rx_first;
    logic [7:0] rx_second;
    logic       setpoint_update;
    logic [5:0] setpoint;
  } res_t;

  logic             accept;
  logic             active, active_next;
  logic [StepW-1:0] step_count, step_next;
  logic [7:0]       tx_shadow, tx_shadow_next;
  logic             high_half_sample, high_half_sample_next;
  logic             scl_reg, scl_next;
  logic             sda_reg, sda_next;
  logic             sda_dir, sda_dir_next;
  logic [2:0]       tx_idx;

  twlm_pkg::rx_ctrl_t ctrl, ctrl_gated;
  logic [RxBits-1:0]  rx_bits;
  logic [7:0]         rx_crc;
  logic [7:0]         last_byte;

  logic out_valid;
  res_t res, res_next;

  assign accept       = ticks.valid && ticks.ready;
  assign ticks.ready  = !out_valid || results.ready;
  assign ctrl_gated   = accept ? ctrl : '0;
  // steps 2..17 send bit (step/2 - 1)
  assign tx_idx       = 3'(step_count[3:1] - 3'd1);
  assign last_byte    = rx_bits[RxBits-1 -: 8];

  twlm_rx_crc #(.RX_BYTES(RX_BYTES)) u_rx (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl_gated),
    .rx_bits (rx_bits),
    .rx_crc  (rx_crc)
  );

  always_comb begin
    active_next           = active;
    step_next             = step_count;
    tx_shadow_next        = tx_shadow;
    high_half_sample_next = high_half_sample;
    scl_next              = scl_reg;
    sda_next              = sda_reg;
    sda_dir_next          = sda_dir;
    ctrl                  = '0;
    res_next              = '0;

    if (ticks.cmd) begin
      if (!active) begin
        active_next    = 1'b1;
        step_next      = '0;
        tx_shadow_next = ticks.tx_byte;
      end
    end else if (active) begin
      if (step_count < SEnd) begin
        scl_next = step_count[0];
        if (step_count == SStartHi || step_count == SStopHi) begin
          sda_next = 1'b1;
        end else if (step_count == SStartLo || step_count == SStopLo) begin
          sda_next = 1'b0;
        end else if (step_count < SStopHi) begin
          sda_next = tx_shadow[tx_idx];
        end else if (step_count == SRelease) begin
          sda_dir_next = 1'b0;
        end else if (step_count[0]) begin
          high_half_sample_next = ticks.sda_in;
        end else begin
          // a bit is one only if high in both halves of its clock
          ctrl.shift  = 1'b1;
          ctrl.rx_bit = high_half_sample && ticks.sda_in;
          ctrl.crc_en = step_count < SCrcEnd;
        end
        step_next = step_count + StepW'(1);
      end else begin
        res_next.done_res  = 1'b1;
        res_next.rx_first  = rx_bits[7:0];
        res_next.rx_second = rx_bits[15:8];
        res_next.crc_ok    = last_byte == rx_crc;
        if (res_next.crc_ok && rx_bits[7:0] <= twlm_pkg::SETPOINT_MAX_IN) begin
          res_next.setpoint_update = 1'b1;
          res_next.setpoint = (rx_bits[7:0] == 8'd0) ? 6'd0
                            : 6'({1'b0, rx_bits[4:0]}) + twlm_pkg::SETPOINT_OFFSET;
        end
        ctrl.clear   = 1'b1;
        step_next    = '0;
        active_next  = 1'b0;
        scl_next     = 1'b1;
        sda_next     = 1'b1;
        sda_dir_next = 1'b1;
      end
    end

    res_next.scl_level = scl_next;
    res_next.sda_level = sda_next;
    res_next.sda_drive = sda_dir_next;
    res_next.busy_res  = active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active           <= 1'b0;
      step_count       <= '0;
      tx_shadow        <= '0;
      high_half_sample <= 1'b0;
      scl_reg          <= 1'b1;
      sda_reg          <= 1'b1;
      sda_dir          <= 1'b1;
      out_valid        <= 1'b0;
    end else begin
      if (accept) begin
        active           <= active_next;
        step_count       <= step_next;
        tx_shadow        <= tx_shadow_next;
        high_half_sample <= high_half_sample_next;
        scl_reg          <= scl_next;
        sda_reg          <= sda_next;
        sda_dir          <= sda_dir_next;
        out_valid        <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload holds until the next transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign results.valid           = out_valid;
  assign results.scl_level       = res.scl_level;
  assign results.sda_level       = res.sda_level;
  assign results.sda_drive       = res.sda_drive;
  assign results.busy_res        = res.busy_res;
  assign results.done_res        = res.done_res;
  assign results.crc_ok          = res.crc_ok;
  assign results.rx_first        = res.rx_first;
  assign results.rx_second       = res.rx_second;
  assign results.setpoint_update = res.setpoint_update;
  assign results.setpoint        = res.setpoint;

  `TWLM_ASSERT_IMP(a_release_only_busy, clk, rst, !sda_dir, active,
    "data line released outside a transaction")
  `TWLM_ASSERT_IMP(a_step_bound, clk, rst, 1'b1, step_count <= SEnd,
    "step counter beyond end of schedule")
  `TWLM_ASSERT_NEXT(a_finish_reports, clk, rst,
    accept && !ticks.cmd && active && step_count == SEnd,
    results.valid && results.done_res && !results.busy_res && rx_bits == '0,
    "finish step did not report done and clear the receive bytes")
  `TWLM_ASSERT_IMP(a_update_needs_crc, clk, rst,
    results.valid && results.setpoint_update, results.crc_ok && results.done_res,
    "setpoint update without a good crc")

endmodule

@@ sim/tb_two_wire_link_master_crc8_core.sv @@
// testbench for the two-wire link master core: directed table, then random link transactions
// results are checked against typed rows or an in-bench model of the step schedule and crc
// depends on twlm_pkg, twlm_if and two_wire_link_master_crc8_core
module tb_two_wire_link_master_crc8_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RX         = 3;
  localparam int LINK_END       = twlm_pkg::RX_START + twlm_pkg::STEPS_PER_BYTE * NUM_RX;
  localparam int ITEM_TARGET    = 750;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SHOW_LIMIT     = 10;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       drive;
    logic       busy;
    logic       done;
    logic       ok;
    logic [7:0] rx0;
    logic [7:0] rx1;
    logic       upd;
    logic [5:0] setpt;
  } link_result_t;

  typedef struct packed {
    logic         cmd;
    logic         sda;
    logic [7:0]   tx;
    logic         typed;
    link_result_t want;
  } stim_row_t;

  localparam link_result_t NO_RES      = '0;
  localparam link_result_t IDLE_RES    = '{scl: 1'b1, sda: 1'b1, drive: 1'b1, default: '0};
  localparam link_result_t ARMED_RES   = '{scl: 1'b1, sda: 1'b1, drive: 1'b1, busy: 1'b1,
                                           default: '0};
  localparam link_result_t START_LO_RES = '{drive: 1'b1, busy: 1'b1, default: '0};

  // directed part: idle ticks, arming, start while busy, opening steps of a transfer
  localparam stim_row_t DIRECTED [22] = '{
    '{CMD_TICK,  1'b0, 8'h00, 1'b1, IDLE_RES},
    '{CMD_TICK,  1'b1, 8'hFF, 1'b1, IDLE_RES},
    '{CMD_START, 1'b0, 8'hA5, 1'b1, ARMED_RES},
    '{CMD_START, 1'b1, 8'h5A, 1'b1, ARMED_RES},
    '{CMD_TICK,  1'b1, 8'h00, 1'b1, START_LO_RES},
    '{CMD_TICK,  1'b0, 8'hFF, 1'b1, ARMED_RES},
    '{CMD_TICK,  1'b0, 8'h00, 1'b0, NO_RES},
    '{CMD_TICK,  1'b1, 8'h00, 1'b0, NO_RES},
    '{CMD_TICK,  1'b0, 8'h00, 1'b0, NO_RES},
    '{CMD_TICK,  1'b1, 8'h00, 1'b0, NO_RES},
    '{CMD_START, 1'b1, 8'hFF, 1'b0, NO_RES},
    '{CMD_TICK,  1'b0, 8'h00, 1'b0, NO_RES},
    '{CMD_TICK,  1'b1, 8'h00, 1'b0, NO_RES},
    '{CMD_TICK,  1'b0, 8'h00, 1'b0, NO_RES},
    '{CMD_TICK,  1'b1, 8'h00, 1'b0, NO_RES},
    '{CMD_TICK,  1'b0, 8'h00, 1'b0, NO_RES},
    '{CMD_TICK,  1'b1, 8'h00, 1'b0, NO_RES},
    '{CMD_TICK,  1'b0, 8'h00, 1'b0, NO_RES},
    '{CMD_TICK,  1'b1, 8'h00, 1'b0, NO_RES},
    '{CMD_TICK,  1'b0, 8'h00, 1'b0, NO_RES},
    '{CMD_TICK,  1'b1, 8'h00, 1'b0, NO_RES},
    '{CMD_TICK,  1'b0, 8'h00, 1'b0, NO_RES}
  };

  logic clk = 1'b0;
  logic rst;

  twlm_tick_if   tick_ch ();
  twlm_result_if res_ch ();

  two_wire_link_master_crc8_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .ticks   (tick_ch),
    .results (res_ch)
  );

  always #5 clk = ~clk;

  // model state, reset values
  logic       bus_active   = 1'b0;
  int         step_num     = 0;
  logic [7:0] send_shadow  = 8'h00;
  logic [7:0] rx_buf [NUM_RX] = '{default: 8'h00};
  logic       first_half_hi = 1'b0;
  logic       scl_q        = 1'b1;
  logic       sda_q        = 1'b1;
  logic       drive_q      = 1'b1;

  link_result_t link_expect_q [$];
  int           link_errors = 0;
  logic         calm        = 1'b0;
  int           stall_left  = 0;
  int           quiet_cycles = 0;

  // bytes the link partner answers with; the directed transfer gets all zero
  logic [7:0] rx_plan [NUM_RX] = '{default: 8'h00};

  function automatic logic [7:0] crc8_pair(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] data;
    logic [7:0]  crc;
    logic        fb;
    data = {b, a};
    crc  = 8'h00;
    for (int i = 0; i < 16; i++) begin
      fb  = crc[0] ^ data[i];
      crc = crc >> 1;
      if (fb) crc = crc ^ twlm_pkg::CRC_POLY;
    end
    return crc;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic link_result_t predict_link(input logic cmd, input logic sda,
                                                input logic [7:0] tx);
    link_result_t r;
    int           idx;
    int           bitn;
    r = '0;
    if (cmd == CMD_START) begin
      if (!bus_active) begin
        bus_active  = 1'b1;
        step_num    = 0;
        send_shadow = tx;
      end
    end else if (bus_active) begin
      if (step_num < LINK_END) begin
        scl_q = step_num[0];
        if (step_num == twlm_pkg::STEP_START_HI ||
            step_num == twlm_pkg::STEP_STOP_HI) begin
          sda_q = 1'b1;
        end else if (step_num == twlm_pkg::STEP_START_LO ||
                     step_num == twlm_pkg::STEP_STOP_LO) begin
          sda_q = 1'b0;
        end else if (step_num < twlm_pkg::STEP_STOP_HI) begin
          sda_q = send_shadow[(step_num / 2 - 1) % 8];
        end else if (step_num == twlm_pkg::STEP_RELEASE) begin
          drive_q = 1'b0;
        end else if (step_num % 2 == 1) begin
          first_half_hi = sda;
        end else if (first_half_hi && sda) begin
          idx  = (step_num - twlm_pkg::RX_START) / twlm_pkg::STEPS_PER_BYTE;
          bitn = ((step_num - twlm_pkg::RX_START) / 2) % 8;
          rx_buf[idx][bitn] = 1'b1;
        end
        step_num++;
      end else begin
        r.done = 1'b1;
        r.rx0  = rx_buf[0];
        r.rx1  = rx_buf[1];
        r.ok   = (rx_buf[2] == crc8_pair(rx_buf[0], rx_buf[1]));
        if (r.ok && rx_buf[0] <= twlm_pkg::SETPOINT_MAX_IN) begin
          r.upd   = 1'b1;
          r.setpt = (rx_buf[0] == 8'd0) ? 6'd0
                  : rx_buf[0][5:0] + twlm_pkg::SETPOINT_OFFSET;
        end
        rx_buf     = '{default: 8'h00};
        step_num   = 0;
        bus_active = 1'b0;
        scl_q      = 1'b1;
        sda_q      = 1'b1;
        drive_q    = 1'b1;
      end
    end
    r.scl   = scl_q;
    r.sda   = sda_q;
    r.drive = drive_q;
    r.busy  = bus_active;
    return r;
  endfunction

  task automatic send_item(input logic cmd, input logic sda, input logic [7:0] tx,
                           input logic typed, input link_result_t want);
    int           gap;
    link_result_t pred;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      tick_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    tick_ch.valid   <= 1'b1;
    tick_ch.cmd     <= cmd;
    tick_ch.sda_in  <= sda;
    tick_ch.tx_byte <= tx;
    do @(posedge clk); while (tick_ch.ready !== 1'b1);
    pred = predict_link(cmd, sda, tx);
    link_expect_q.push_back(typed ? want : pred);
  endtask

  // result side back-pressure
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      res_ch.ready <= 1'b1;
      stall_left   <= calm ? 0 : pick_gap();
    end
  end

  always @(posedge clk) begin
    link_result_t got;
    link_result_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      got = '{res_ch.scl_level, res_ch.sda_level, res_ch.sda_drive, res_ch.busy_res,
              res_ch.done_res, res_ch.crc_ok, res_ch.rx_first, res_ch.rx_second,
              res_ch.setpoint_update, res_ch.setpoint};
      if (link_expect_q.size() == 0) begin
        if (link_errors < SHOW_LIMIT)
          $display("%0t: result transfer with nothing expected", $realtime);
        link_errors++;
      end else begin
        want = link_expect_q.pop_front();
        if (got.scl !== want.scl || got.sda !== want.sda || got.drive !== want.drive ||
            got.busy !== want.busy || got.done !== want.done || got.ok !== want.ok ||
            got.rx0 !== want.rx0 || got.rx1 !== want.rx1 || got.upd !== want.upd ||
            got.setpt !== want.setpt) begin
          if (link_errors < SHOW_LIMIT) begin
            $write("%0t: mismatch exp scl %b sda %b drv %b busy %b done %b ok %b",
                   $realtime, want.scl, want.sda, want.drive, want.busy, want.done,
                   want.ok);
            $display(" rx %h %h upd %b sp %0d", want.rx0, want.rx1, want.upd, want.setpt);
            $write("%0t:          got scl %b sda %b drv %b busy %b done %b ok %b",
                   $realtime, got.scl, got.sda, got.drive, got.busy, got.done,
                   got.ok);
            $display(" rx %h %h upd %b sp %0d", got.rx0, got.rx1, got.upd, got.setpt);
          end
          link_errors++;
        end
      end
    end
  end

  // cycles without any transfer
  always @(posedge clk) begin
    if (rst || (tick_ch.valid === 1'b1 && tick_ch.ready === 1'b1) ||
        (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int         counted;
    int         bitpos;
    logic       c;
    logic       s;
    logic       prev_half;
    logic [7:0] t;
    counted         = 0;
    prev_half       = 1'b0;
    rst             = 1'b1;
    tick_ch.valid   = 1'b0;
    tick_ch.cmd     = CMD_TICK;
    tick_ch.sda_in  = 1'b0;
    tick_ch.tx_byte = 8'h00;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i])
      send_item(DIRECTED[i].cmd, DIRECTED[i].sda, DIRECTED[i].tx,
                DIRECTED[i].typed, DIRECTED[i].want);

    while (counted < ITEM_TARGET || bus_active) begin
      c = CMD_TICK;
      s = 1'($urandom_range(0, 1));
      t = 8'($urandom_range(0, 255));
      counted++;
      if (!bus_active) begin
        if ($urandom_range(0, 4) != 0) begin
          c = CMD_START;
          calm = ($urandom_range(0, 3) == 0);
          case ($urandom_range(0, 6))
            0:       rx_plan[0] = 8'd0;
            1:       rx_plan[0] = 8'd1;
            2:       rx_plan[0] = twlm_pkg::SETPOINT_MAX_IN;
            3:       rx_plan[0] = twlm_pkg::SETPOINT_MAX_IN + 8'd1;
            4:       rx_plan[0] = 8'hFF;
            5:       rx_plan[0] = 8'($urandom_range(0, twlm_pkg::SETPOINT_MAX_IN));
            default: rx_plan[0] = 8'($urandom_range(0, 255));
          endcase
          rx_plan[1] = 8'($urandom_range(0, 255));
          rx_plan[2] = ($urandom_range(0, 3) != 0) ? crc8_pair(rx_plan[0], rx_plan[1])
                                                    : 8'($urandom_range(0, 255));
        end
      end else if ($urandom_range(0, 24) == 0) begin
        // start while a transfer runs, must be ignored
        c = CMD_START;
      end else begin
        if (step_num >= twlm_pkg::RX_START - 1 && step_num < LINK_END - 1) begin
          bitpos = (step_num - (twlm_pkg::RX_START - 1)) / 2;
          if (rx_plan[bitpos / 8][bitpos % 8])
            s = 1'b1;
          else if (step_num % 2 == 0 && prev_half)
            s = 1'b0;  // a zero bit may still glitch high in one half only
        end
        prev_half = s;
      end
      send_item(c, s, t, 1'b0, NO_RES);
    end
    @(negedge clk);
    tick_ch.valid <= 1'b0;

    while (link_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (link_errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/twlm_pkg.sv
rtl/core/twlm_if.sv
rtl/core/twlm_rx_crc.sv
rtl/core/two_wire_link_master_crc8_core.sv
sim/tb_two_wire_link_master_crc8_core.sv
